FILE: src/czoud_pkg.sv
// Shared types, constants and helpers for the clock zone offset display unit.
// No dependencies; every other file in src imports this package.
package czoud_pkg;

  localparam logic [3:0] DIGIT_BLANK = 4'd15;

  localparam logic signed [5:0] OFF_RESET = -6'sd8;
  localparam logic signed [5:0] OFF_MAX   = 6'sd23;
  localparam logic signed [5:0] OFF_MIN   = -6'sd23;

  localparam logic signed [7:0] HOURS_DAY = 8'sd24;

  localparam logic FUNC_POLL = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  // Button bit positions
  localparam int BTN_DOWN = 0;
  localparam int BTN_UP   = 1;
  localparam int BTN_MODE = 3;

  typedef enum logic [2:0] {
    MENU_TIME      = 3'd0,
    MENU_ENTER     = 3'd1,
    MENU_SETTING   = 3'd2,
    MENU_LEAVE     = 3'd3,
    MENU_UP_HELD   = 3'd4,
    MENU_DOWN_HELD = 3'd5
  } menu_state_t;

  typedef struct packed {
    logic       func;
    logic [5:0] buttons;
    logic [1:0] hour_tens_in;
    logic [3:0] hour_ones_in;
    logic [2:0] minute_tens_in;
    logic [3:0] minute_ones_in;
    logic [2:0] second_tens_in;
    logic [3:0] second_ones_in;
  } in_word_t;

  typedef struct packed {
    logic [3:0] digit_a;
    logic [3:0] digit_b;
    logic [3:0] digit_c;
    logic [3:0] digit_d;
    logic [3:0] digit_e;
    logic [3:0] digit_f;
    logic       showing_offset;
  } out_word_t;

  // Split a value below 64 into tens and ones: {tens, ones}
  function automatic logic [7:0] split_dec(input logic [5:0] v);
    logic [3:0] q;
    logic [5:0] r;
    if (v >= 6'd60)      q = 4'd6;
    else if (v >= 6'd50) q = 4'd5;
    else if (v >= 6'd40) q = 4'd4;
    else if (v >= 6'd30) q = 4'd3;
    else if (v >= 6'd20) q = 4'd2;
    else if (v >= 6'd10) q = 4'd1;
    else                 q = 4'd0;
    r = v - ({2'b00, q} * 6'd10);
    return {q, r[3:0]};
  endfunction

endpackage

FILE: src/czoud_if.sv
// Valid/ready channel interfaces for the input and result words.
// Depends on czoud_pkg for the payload structs.
interface czoud_in_if import czoud_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface czoud_out_if import czoud_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/clock_zone_offset_ui_display_unit.sv
// Top level of the clock zone offset display unit: menu machine, zone offset,
// stored time digits and digit formatting. Uses czoud_pkg and czoud_if.
//
//   channel   dir   payload       handshake
//   in_ch     in    in_word_t     valid/ready, load or poll word
//   out_ch    out   out_word_t    valid/ready, one word per poll
//
// One word per cycle sustained while results are taken; a poll result passes
// through the input register, then the result register.
// A load word updates the stored digits and yields no result.
// A full result register that is not taken stalls the input register for polls.
// Reset (rst_n low, synchronous) sets the menu to time view, offset to -8,
// and clears the stored digits.
module clock_zone_offset_ui_display_unit
  import czoud_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  czoud_in_if.sink     in_ch,
  czoud_out_if.source  out_ch
);

  // Input register
  logic     s1_valid_r;
  in_word_t s1_word_r;

  // State
  menu_state_t      menu_r, menu_nxt;
  logic signed [5:0] off_r, off_nxt;
  logic [1:0] hour_tens_r;
  logic [3:0] hour_ones_r;
  logic [2:0] minute_tens_r;
  logic [3:0] minute_ones_r;
  logic [2:0] second_tens_r;
  logic [3:0] second_ones_r;

  // Result register
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r, out_word_nxt;

  logic s1_go, poll_go, load_go;
  logic btn_up, btn_down, btn_mode;
  logic signed [5:0] off_after_up;
  logic offset_view;
  logic [5:0] hour_bin;
  logic signed [7:0] hour_sum, hour_adj;
  logic [4:0] off_mag;
  logic [7:0] hour_split, off_split;

  assign s1_go   = s1_valid_r && (s1_word_r.func == FUNC_LOAD || !out_valid_r || out_ch.ready);
  assign poll_go = s1_go && (s1_word_r.func == FUNC_POLL);
  assign load_go = s1_go && (s1_word_r.func == FUNC_LOAD);

  assign in_ch.ready  = !s1_valid_r || s1_go;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;

  assign btn_down = s1_word_r.buttons[BTN_DOWN];
  assign btn_up   = s1_word_r.buttons[BTN_UP];
  assign btn_mode = s1_word_r.buttons[BTN_MODE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      s1_word_r <= in_ch.data;
    end
  end

  // Menu next state
  always_comb begin
    menu_nxt = menu_r;
    if (poll_go) begin
      case (menu_r)
        MENU_TIME: begin
          if (btn_mode) menu_nxt = MENU_ENTER;
        end
        MENU_ENTER: begin
          if (!btn_mode) menu_nxt = MENU_SETTING;
        end
        MENU_SETTING: begin
          // of up, down and mode, the last in that order wins (mode has priority)
          if (btn_up)   menu_nxt = MENU_UP_HELD;
          if (btn_down) menu_nxt = MENU_DOWN_HELD;
          if (btn_mode) menu_nxt = MENU_LEAVE;
        end
        MENU_LEAVE: begin
          if (!btn_mode) menu_nxt = MENU_TIME;
        end
        MENU_UP_HELD: begin
          if (!btn_up) menu_nxt = MENU_SETTING;
        end
        MENU_DOWN_HELD: begin
          if (!btn_down) menu_nxt = MENU_SETTING;
        end
        default: begin
          menu_nxt = MENU_TIME;
        end
      endcase
    end
  end

  // Offset update and digit formatting
  always_comb begin
    off_after_up = off_r;
    if (poll_go && menu_r == MENU_SETTING && btn_up && off_r != OFF_MAX) begin
      off_after_up = off_r + 6'sd1;
    end
    off_nxt = off_after_up;
    if (poll_go && menu_r == MENU_SETTING && btn_down && off_after_up != OFF_MIN) begin
      off_nxt = off_after_up - 6'sd1;
    end

    offset_view = (menu_r == MENU_SETTING) || (menu_r == MENU_LEAVE) ||
                  (menu_r == MENU_UP_HELD) || (menu_r == MENU_DOWN_HELD);

    hour_bin = ({4'b0000, hour_tens_r} * 6'd10) + {2'b00, hour_ones_r};
    hour_sum = $signed({2'b00, hour_bin}) + {{2{off_nxt[5]}}, off_nxt};
    if (hour_sum < 0)              hour_adj = hour_sum + HOURS_DAY;
    else if (hour_sum >= HOURS_DAY) hour_adj = hour_sum - HOURS_DAY;
    else                            hour_adj = hour_sum;
    hour_split = split_dec(hour_adj[5:0]);

    off_mag   = off_nxt[5] ? 5'(-off_nxt) : off_nxt[4:0];
    off_split = split_dec({1'b0, off_mag});

    out_word_nxt.showing_offset = offset_view;
    if (!offset_view) begin
      out_word_nxt.digit_a = hour_split[7:4];
      out_word_nxt.digit_b = hour_split[3:0];
      out_word_nxt.digit_c = {1'b0, minute_tens_r};
      out_word_nxt.digit_d = minute_ones_r;
      out_word_nxt.digit_e = {1'b0, second_tens_r};
      out_word_nxt.digit_f = second_ones_r;
    end else if (off_nxt[5]) begin
      // negative offset shows on the right
      out_word_nxt.digit_a = DIGIT_BLANK;
      out_word_nxt.digit_b = DIGIT_BLANK;
      out_word_nxt.digit_c = DIGIT_BLANK;
      out_word_nxt.digit_d = DIGIT_BLANK;
      out_word_nxt.digit_e = off_split[7:4];
      out_word_nxt.digit_f = off_split[3:0];
    end else begin
      out_word_nxt.digit_a = off_split[7:4];
      out_word_nxt.digit_b = off_split[3:0];
      out_word_nxt.digit_c = DIGIT_BLANK;
      out_word_nxt.digit_d = DIGIT_BLANK;
      out_word_nxt.digit_e = DIGIT_BLANK;
      out_word_nxt.digit_f = DIGIT_BLANK;
    end

    if (poll_go)           out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
    else                   out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      menu_r        <= MENU_TIME;
      off_r         <= OFF_RESET;
      hour_tens_r   <= '0;
      hour_ones_r   <= '0;
      minute_tens_r <= '0;
      minute_ones_r <= '0;
      second_tens_r <= '0;
      second_ones_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      menu_r      <= menu_nxt;
      off_r       <= off_nxt;
      out_valid_r <= out_valid_nxt;
      if (load_go) begin
        hour_tens_r   <= s1_word_r.hour_tens_in;
        hour_ones_r   <= s1_word_r.hour_ones_in;
        minute_tens_r <= s1_word_r.minute_tens_in;
        minute_ones_r <= s1_word_r.minute_ones_in;
        second_tens_r <= s1_word_r.second_tens_in;
        second_ones_r <= s1_word_r.second_ones_in;
      end
    end
    if (poll_go) begin
      out_word_r <= out_word_nxt;
    end
  end

  // Offset stays within the clamp range
  a_off_range: assert property (@(posedge clk) disable iff (!rst_n)
    (off_r <= OFF_MAX) && (off_r >= OFF_MIN))
    else $error("zone offset out of range");

  // Offset only moves on a poll taken in the setting state
  a_off_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(poll_go && menu_r == MENU_SETTING) |=> $stable(off_r))
    else $error("zone offset changed outside setting");

  // A load word never creates a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    load_go |=> out_valid_r == $past(out_valid_r && !out_ch.ready))
    else $error("load word produced a result");

  // Offset view always blanks the middle digits
  a_offset_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.showing_offset) |->
      (out_word_r.digit_c == DIGIT_BLANK && out_word_r.digit_d == DIGIT_BLANK))
    else $error("offset view without blanks");

endmodule
